// ===== rtl/ckc_pkg.sv =====
// Shared types, constants and field arithmetic for the three-key clock-set controller.
`default_nettype none

package ckc_pkg;

  localparam int LONG_PRESS_TICKS = 40;
  localparam int HOLD_W = 6;
  localparam int FIELD_CNT = 6;
  localparam int VAL_W = 7;

  localparam logic [2:0] BRIGHT_MIN = 3'd1;
  localparam logic [2:0] BRIGHT_MAX = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_LONG  = 2'd2
  } ckc_event_t;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } ckc_field_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ckc_time_t;

  typedef struct packed {
    logic      key_down_level;
    logic      key_up_level;
    logic      key_mode_level;
    ckc_time_t now;
  } ckc_in_word_t;

  function automatic logic [VAL_W-1:0] field_min(input logic [2:0] f);
    logic [VAL_W-1:0] m;
    case (f)
      FLD_YEAR:  m = 7'd23;
      FLD_MONTH: m = 7'd1;
      FLD_DAY:   m = 7'd1;
      default:   m = 7'd0;
    endcase
    return m;
  endfunction

  function automatic logic [VAL_W-1:0] field_max(input logic [2:0] f);
    logic [VAL_W-1:0] m;
    case (f)
      FLD_YEAR:  m = 7'd99;
      FLD_MONTH: m = 7'd12;
      FLD_DAY:   m = 7'd31;
      FLD_HOUR:  m = 7'd23;
      default:   m = 7'd59;
    endcase
    return m;
  endfunction

  // Step one edit value with wrap; values outside the range are kept until stepped.
  function automatic logic [VAL_W-1:0] field_step(input logic [VAL_W-1:0] v,
                                                  input logic [2:0] f,
                                                  input logic up);
    logic [VAL_W:0]   v_inc;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] r;
    lo = field_min(f);
    hi = field_max(f);
    v_inc = {1'b0, v} + {{VAL_W{1'b0}}, 1'b1};
    if (up) begin
      r = (v_inc > {1'b0, hi}) ? lo : v_inc[VAL_W-1:0];
    end else begin
      r = (v <= lo) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ckc_in_if.sv =====
// Input channel: one key sample and current time per word.
`default_nettype none

interface ckc_in_if;
  logic       valid;
  logic       ready;
  logic       key_down_level;
  logic       key_up_level;
  logic       key_mode_level;
  logic [6:0] now_year;
  logic [3:0] now_month;
  logic [4:0] now_day;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic [5:0] now_second;

  modport source (output valid, key_down_level, key_up_level, key_mode_level,
                  now_year, now_month, now_day, now_hour, now_minute, now_second,
                  input ready);
  modport sink (input valid, key_down_level, key_up_level, key_mode_level,
                now_year, now_month, now_day, now_hour, now_minute, now_second,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ckc_out_if.sv =====
// Output channel: controller status and edit values per word.
`default_nettype none

interface ckc_out_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [2:0] brightness_level;
  logic [2:0] edit_field;
  logic       save_strobe;
  logic [6:0] set_year;
  logic [3:0] set_month;
  logic [4:0] set_day;
  logic [4:0] set_hour;
  logic [5:0] set_minute;
  logic [5:0] set_second;

  modport source (output valid, mode, brightness_level, edit_field, save_strobe,
                  set_year, set_month, set_day, set_hour, set_minute, set_second,
                  input ready);
  modport sink (input valid, mode, brightness_level, edit_field, save_strobe,
                set_year, set_month, set_day, set_hour, set_minute, set_second,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ckc_key_tracker.sv =====
// Press / long-press tracker for one active-low key.
`default_nettype none

module ckc_key_tracker
  import ckc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       level,
  output ckc_event_t event_out
);

  typedef enum logic [1:0] {
    PH_PRESSED  = 2'd0,
    PH_RELEASED = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [HOLD_W-1:0] hold_ticks;
  logic [HOLD_W-1:0] hold_ticks_next;
  logic [HOLD_W-1:0] hold_inc;

  assign hold_inc = hold_ticks + HOLD_W'(1);

  always_comb begin
    phase_next      = phase;
    hold_ticks_next = hold_ticks;
    event_out       = EV_NONE;
    if (level) begin
      phase_next      = PH_RELEASED;
      hold_ticks_next = '0;
    end else begin
      case (phase)
        PH_RELEASED: begin
          phase_next      = PH_PRESSED;
          hold_ticks_next = '0;
          event_out       = EV_PRESS;
        end
        PH_PRESSED: begin
          hold_ticks_next = hold_inc;
          if (hold_inc >= HOLD_W'(LONG_PRESS_TICKS)) begin
            phase_next = PH_LONG;
            event_out  = EV_LONG;
          end
        end
        // long held: quiet until release
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RELEASED;
      hold_ticks <= '0;
    end else if (en) begin
      phase      <= phase_next;
      hold_ticks <= hold_ticks_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ckc_ui_core.sv =====
// Mode, brightness and time-edit state; the state registers double as the result word.
`default_nettype none

module ckc_ui_core
  import ckc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  ckc_event_t ev_down,
  input  ckc_event_t ev_up,
  input  ckc_event_t ev_mode,
  input  ckc_time_t  now,
  output logic       mode,
  output logic [2:0] brightness,
  output logic [2:0] field_index,
  output logic       save_strobe,
  output ckc_time_t  edit_time
);

  logic [VAL_W-1:0] edit_values [FIELD_CNT];
  logic [VAL_W-1:0] edit_values_next [FIELD_CNT];
  logic             mode_next;
  logic [2:0]       brightness_next;
  logic [2:0]       bright_mid;
  logic [2:0]       field_index_next;
  logic             save_next;
  logic             field_ok;
  logic [VAL_W-1:0] cur_val;
  logic [VAL_W-1:0] mid_val;
  logic [VAL_W-1:0] new_val;
  logic             down_press;
  logic             up_press;

  assign down_press = (ev_down == EV_PRESS);
  assign up_press   = (ev_up == EV_PRESS);
  assign field_ok   = (field_index <= FLD_SECOND);
  assign cur_val    = field_ok ? edit_values[field_index[2:0]] : '0;

  // down is handled before up, so both in one tick chain through
  assign mid_val = down_press ? field_step(cur_val, field_index, 1'b0) : cur_val;
  assign new_val = up_press ? field_step(mid_val, field_index, 1'b1) : mid_val;

  assign bright_mid = (down_press && brightness > BRIGHT_MIN) ? brightness - 3'd1 :
                      (down_press ? BRIGHT_MIN : brightness);

  always_comb begin
    mode_next        = mode;
    brightness_next  = brightness;
    field_index_next = field_index;
    save_next        = 1'b0;
    for (int i = 0; i < FIELD_CNT; i++) begin
      edit_values_next[i] = edit_values[i];
    end
    if (!mode) begin
      brightness_next = (up_press && bright_mid < BRIGHT_MAX) ? bright_mid + 3'd1 :
                        (up_press ? BRIGHT_MAX : bright_mid);
      if (ev_mode == EV_LONG) begin
        edit_values_next[FLD_YEAR]   = now.year;
        edit_values_next[FLD_MONTH]  = VAL_W'(now.month);
        edit_values_next[FLD_DAY]    = VAL_W'(now.day);
        edit_values_next[FLD_HOUR]   = VAL_W'(now.hour);
        edit_values_next[FLD_MINUTE] = VAL_W'(now.minute);
        edit_values_next[FLD_SECOND] = VAL_W'(now.second);
        field_index_next = FLD_YEAR;
        mode_next        = 1'b1;
      end
    end else begin
      if (field_ok) begin
        edit_values_next[field_index[2:0]] = new_val;
      end
      if (ev_mode == EV_PRESS) begin
        field_index_next = (field_index >= FLD_SECOND) ? FLD_YEAR : field_index + 3'd1;
      end else if (ev_mode == EV_LONG) begin
        save_next = 1'b1;
        mode_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      brightness  <= BRIGHT_MAX;
      field_index <= FLD_YEAR;
      save_strobe <= 1'b0;
      for (int i = 0; i < FIELD_CNT; i++) begin
        edit_values[i] <= '0;
      end
    end else if (en) begin
      mode        <= mode_next;
      brightness  <= brightness_next;
      field_index <= field_index_next;
      save_strobe <= save_next;
      for (int i = 0; i < FIELD_CNT; i++) begin
        edit_values[i] <= edit_values_next[i];
      end
    end
  end

  assign edit_time.year   = edit_values[FLD_YEAR];
  assign edit_time.month  = edit_values[FLD_MONTH][3:0];
  assign edit_time.day    = edit_values[FLD_DAY][4:0];
  assign edit_time.hour   = edit_values[FLD_HOUR][4:0];
  assign edit_time.minute = edit_values[FLD_MINUTE][5:0];
  assign edit_time.second = edit_values[FLD_SECOND][5:0];

endmodule

`default_nettype wire

// ===== rtl/three_key_clock_set_controller.sv =====
// Top level of the three-key clock-set controller.
// Each input word is one key tick: three active-low key levels plus the current time.
// The word lands in an input register; when it advances (a waiting result stalls it), the
// key trackers and the mode/brightness/edit logic update in a single pass; the updated state
// registers are the result word, which turns valid as they update. One word per clock cycle
// is sustained while results are taken. A waiting result holds the word in the input
// register, so at most one more input word enters while a result waits. Key events are
// handled down, up, then mode within a tick; a long press needs LONG_PRESS_TICKS further
// low ticks after the press tick.
`default_nettype none

module three_key_clock_set_controller
  import ckc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ckc_in_if.sink           tick_in,
  ckc_out_if.source        tick_out
);

  logic         s1_valid;
  ckc_in_word_t s1_word;
  logic         advance;
  ckc_event_t   ev_down;
  ckc_event_t   ev_up;
  ckc_event_t   ev_mode;
  ckc_time_t    edit_time;

  assign advance       = s1_valid && (!tick_out.valid || tick_out.ready);
  assign tick_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      tick_out.valid <= 1'b0;
    end else begin
      if (tick_in.ready) begin
        s1_valid <= tick_in.valid;
      end
      if (advance) begin
        tick_out.valid <= 1'b1;
      end else if (tick_out.ready) begin
        tick_out.valid <= 1'b0;
      end
    end
  end

  // hold the input word until it advances
  always_ff @(posedge clk) begin
    if (tick_in.valid && tick_in.ready) begin
      s1_word.key_down_level <= tick_in.key_down_level;
      s1_word.key_up_level   <= tick_in.key_up_level;
      s1_word.key_mode_level <= tick_in.key_mode_level;
      s1_word.now.year       <= tick_in.now_year;
      s1_word.now.month      <= tick_in.now_month;
      s1_word.now.day        <= tick_in.now_day;
      s1_word.now.hour       <= tick_in.now_hour;
      s1_word.now.minute     <= tick_in.now_minute;
      s1_word.now.second     <= tick_in.now_second;
    end
  end

  ckc_key_tracker u_key_down (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .level     (s1_word.key_down_level),
    .event_out (ev_down)
  );

  ckc_key_tracker u_key_up (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .level     (s1_word.key_up_level),
    .event_out (ev_up)
  );

  ckc_key_tracker u_key_mode (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .level     (s1_word.key_mode_level),
    .event_out (ev_mode)
  );

  ckc_ui_core u_ui (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .ev_down     (ev_down),
    .ev_up       (ev_up),
    .ev_mode     (ev_mode),
    .now         (s1_word.now),
    .mode        (tick_out.mode),
    .brightness  (tick_out.brightness_level),
    .field_index (tick_out.edit_field),
    .save_strobe (tick_out.save_strobe),
    .edit_time   (edit_time)
  );

  assign tick_out.set_year   = edit_time.year;
  assign tick_out.set_month  = edit_time.month;
  assign tick_out.set_day    = edit_time.day;
  assign tick_out.set_hour   = edit_time.hour;
  assign tick_out.set_minute = edit_time.minute;
  assign tick_out.set_second = edit_time.second;

endmodule

`default_nettype wire

// ===== tb/tb_three_key_clock_set_controller.sv =====
// Testbench for the three-key clock-set controller: directed table, then random key traffic.
`timescale 1ns / 100ps

module tb_three_key_clock_set_controller
  import ckc_pkg::*;
();

  localparam int KEY_DOWN = 0;
  localparam int KEY_UP = 1;
  localparam int KEY_MODE = 2;
  localparam int RANDOM_TICKS = 1250;
  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    PH_PRESSED  = 2'd0,
    PH_RELEASED = 2'd1,
    PH_HELD     = 2'd2
  } key_phase_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] bright;
    logic [2:0] field;
    logic       save;
    ckc_time_t  t;
  } panel_t;

  typedef struct {
    logic      dn;
    logic      up;
    logic      md;
    ckc_time_t now;
    int        reps;
    bit        typed;
    panel_t    want;
  } script_row_t;

  localparam ckc_time_t ZERO_T = '0;
  localparam ckc_time_t TOP_T = '{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};

  logic clk;
  logic rst;

  ckc_in_if  tick_in_bus ();
  ckc_out_if tick_out_bus ();

  three_key_clock_set_controller u_top (
    .clk      (clk),
    .rst      (rst),
    .tick_in  (tick_in_bus),
    .tick_out (tick_out_bus)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state
  key_phase_t key_st [3];
  logic [5:0] held [3];
  logic       set_mode;
  logic [2:0] bright;
  logic [2:0] sel;
  logic [6:0] edit_val [6];

  panel_t      panel_due [$];
  script_row_t script [$];
  int          fails;
  int          ticks_sent;
  int          stall_cnt;
  bit          calm;

  function automatic logic [6:0] nudge(input logic [6:0] v, input logic [2:0] f, input bit up);
    logic [7:0] lo;
    logic [7:0] hi;
    case (f)
      FLD_YEAR: begin
        lo = 8'd23;
        hi = 8'd99;
      end
      FLD_MONTH: begin
        lo = 8'd1;
        hi = 8'd12;
      end
      FLD_DAY: begin
        lo = 8'd1;
        hi = 8'd31;
      end
      FLD_HOUR: begin
        lo = 8'd0;
        hi = 8'd23;
      end
      default: begin
        lo = 8'd0;
        hi = 8'd59;
      end
    endcase
    if (up) return (({1'b0, v} + 8'd1) > hi) ? lo[6:0] : v + 7'd1;
    return ({1'b0, v} < (lo + 8'd1)) ? hi[6:0] : v - 7'd1;
  endfunction

  function automatic panel_t next_panel(input ckc_in_word_t w);
    logic [2:0] lv;
    ckc_event_t ev [3];
    logic       strobe;
    panel_t     p;
    int         k;
    lv = {w.key_mode_level, w.key_up_level, w.key_down_level};
    strobe = 1'b0;
    for (k = 0; k < 3; k++) begin
      ev[k] = EV_NONE;
      if (lv[k]) begin
        key_st[k] = PH_RELEASED;
        held[k] = '0;
      end else if (key_st[k] == PH_RELEASED) begin
        key_st[k] = PH_PRESSED;
        held[k] = '0;
        ev[k] = EV_PRESS;
      end else if (key_st[k] == PH_PRESSED) begin
        held[k] = held[k] + 6'd1;
        if (held[k] >= LONG_PRESS_TICKS) begin
          key_st[k] = PH_HELD;
          ev[k] = EV_LONG;
        end
      end
    end
    for (k = 0; k < 3; k++) begin
      if (!set_mode) begin
        if (k == KEY_DOWN && ev[k] == EV_PRESS) begin
          bright = (bright > BRIGHT_MIN) ? bright - 3'd1 : BRIGHT_MIN;
        end else if (k == KEY_UP && ev[k] == EV_PRESS) begin
          bright = (bright < BRIGHT_MAX) ? bright + 3'd1 : BRIGHT_MAX;
        end else if (k == KEY_MODE && ev[k] == EV_LONG) begin
          edit_val[0] = w.now.year;
          edit_val[1] = {3'd0, w.now.month};
          edit_val[2] = {2'd0, w.now.day};
          edit_val[3] = {2'd0, w.now.hour};
          edit_val[4] = {1'b0, w.now.minute};
          edit_val[5] = {1'b0, w.now.second};
          sel = FLD_YEAR;
          set_mode = 1'b1;
        end
      end else begin
        if (k == KEY_DOWN && ev[k] == EV_PRESS) begin
          if (sel <= FLD_SECOND) edit_val[sel] = nudge(edit_val[sel], sel, 1'b0);
        end else if (k == KEY_UP && ev[k] == EV_PRESS) begin
          if (sel <= FLD_SECOND) edit_val[sel] = nudge(edit_val[sel], sel, 1'b1);
        end else if (k == KEY_MODE && ev[k] == EV_PRESS) begin
          sel = (sel >= FLD_SECOND) ? 3'(FLD_YEAR) : sel + 3'd1;
        end else if (k == KEY_MODE && ev[k] == EV_LONG) begin
          strobe = 1'b1;
          set_mode = 1'b0;
        end
      end
    end
    p.mode = set_mode;
    p.bright = bright;
    p.field = sel;
    p.save = strobe;
    p.t.year = edit_val[0];
    p.t.month = edit_val[1][3:0];
    p.t.day = edit_val[2][4:0];
    p.t.hour = edit_val[3][4:0];
    p.t.minute = edit_val[4][5:0];
    p.t.second = edit_val[5][5:0];
    return p;
  endfunction

  function automatic logic [6:0] pick_val(input int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(hi);
    return 7'($urandom_range(0, hi));
  endfunction

  function automatic ckc_time_t pick_time();
    ckc_time_t t;
    t.year = pick_val(99);
    t.month = 4'(pick_val(12));
    t.day = 5'(pick_val(31));
    t.hour = 5'(pick_val(23));
    t.minute = 6'(pick_val(59));
    t.second = 6'(pick_val(59));
    return t;
  endfunction

  function automatic void add_row(input logic dn, input logic up, input logic md,
                                  input ckc_time_t now, input int reps,
                                  input bit typed, input panel_t want);
    script.push_back('{dn, up, md, now, reps, typed, want});
  endfunction

  // Send one tick word, then record what it should produce.
  task automatic play_tick(input ckc_in_word_t w, input bit typed, input panel_t want);
    panel_t p;
    if (!calm && $urandom_range(0, 99) < 25) begin
      tick_in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    tick_in_bus.valid <= 1'b1;
    tick_in_bus.key_down_level <= w.key_down_level;
    tick_in_bus.key_up_level <= w.key_up_level;
    tick_in_bus.key_mode_level <= w.key_mode_level;
    tick_in_bus.now_year <= w.now.year;
    tick_in_bus.now_month <= w.now.month;
    tick_in_bus.now_day <= w.now.day;
    tick_in_bus.now_hour <= w.now.hour;
    tick_in_bus.now_minute <= w.now.minute;
    tick_in_bus.now_second <= w.now.second;
    @(posedge clk);
    while (!tick_in_bus.ready) @(posedge clk);
    p = next_panel(w);
    panel_due.push_back(typed ? want : p);
    ticks_sent++;
  endtask

  // Hold the given keys low for a while, then release everything.
  task automatic tap_keys(input logic dn, input logic up, input logic md,
                          input int lows, input int rels);
    int i;
    for (i = 0; i < lows; i++) play_tick(ckc_in_word_t'({dn, up, md, pick_time()}), 1'b0, '0);
    for (i = 0; i < rels; i++) play_tick(ckc_in_word_t'({3'b111, pick_time()}), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    panel_t want;
    if (!rst && tick_out_bus.valid && tick_out_bus.ready) begin
      if (panel_due.size() == 0) begin
        $error("result word with no expectation pending");
        fails++;
      end else begin
        want = panel_due.pop_front();
        check_field("mode", want.mode, tick_out_bus.mode);
        check_field("brightness_level", want.bright, tick_out_bus.brightness_level);
        check_field("edit_field", want.field, tick_out_bus.edit_field);
        check_field("save_strobe", want.save, tick_out_bus.save_strobe);
        check_field("set_year", want.t.year, tick_out_bus.set_year);
        check_field("set_month", want.t.month, tick_out_bus.set_month);
        check_field("set_day", want.t.day, tick_out_bus.set_day);
        check_field("set_hour", want.t.hour, tick_out_bus.set_hour);
        check_field("set_minute", want.t.minute, tick_out_bus.set_minute);
        check_field("set_second", want.t.second, tick_out_bus.set_second);
      end
    end
    tick_out_bus.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    if ((tick_in_bus.valid && tick_in_bus.ready) ||
        (tick_out_bus.valid && tick_out_bus.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("FAIL three_key_clock_set_controller");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int r;
    int sel_kind;
    int base;
    logic [2:0] m;
    rst = 1'b1;
    calm = 1'b0;
    fails = 0;
    ticks_sent = 0;
    stall_cnt = 0;
    tick_in_bus.valid = 1'b0;
    tick_in_bus.key_down_level = 1'b1;
    tick_in_bus.key_up_level = 1'b1;
    tick_in_bus.key_mode_level = 1'b1;
    tick_in_bus.now_year = '0;
    tick_in_bus.now_month = '0;
    tick_in_bus.now_day = '0;
    tick_in_bus.now_hour = '0;
    tick_in_bus.now_minute = '0;
    tick_in_bus.now_second = '0;
    tick_out_bus.ready = 1'b0;
    for (i = 0; i < 3; i++) begin
      key_st[i] = PH_RELEASED;
      held[i] = '0;
    end
    set_mode = 1'b0;
    bright = BRIGHT_MAX;
    sel = FLD_YEAR;
    for (i = 0; i < 6; i++) edit_val[i] = '0;

    // Reset state, brightness saturation at both ends, a both-key tick
    add_row(1, 1, 1, TOP_T, 1, 1, panel_t'{1'b0, 3'd4, 3'd0, 1'b0, ZERO_T});
    add_row(1, 0, 1, ZERO_T, 1, 1, panel_t'{1'b0, 3'd4, 3'd0, 1'b0, ZERO_T});
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 1, 1, ZERO_T, 1, 1, panel_t'{1'b0, 3'd1, 3'd0, 1'b0, ZERO_T});
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 0, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    // Long mode press copies the time at its tick; further holding is silent
    add_row(1, 1, 0, ZERO_T, 40, 0, '0);
    add_row(1, 1, 0, TOP_T, 1, 1, panel_t'{1'b1, 3'd2, 3'd0, 1'b0, TOP_T});
    add_row(1, 1, 0, ZERO_T, 3, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    // Year wraps both ways, then month up past the top
    add_row(1, 0, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(0, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 1, 0, ZERO_T, 1, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);
    add_row(1, 0, 1, ZERO_T, 1, 0, '0);
    // Press advances the field, the long press saves
    add_row(1, 1, 0, ZERO_T, 41, 0, '0);
    add_row(1, 1, 1, ZERO_T, 1, 0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      for (r = 0; r < script[i].reps; r++) begin
        play_tick(ckc_in_word_t'({script[i].dn, script[i].up, script[i].md, script[i].now}),
                  script[i].typed, script[i].want);
      end
    end

    base = ticks_sent;
    while (ticks_sent < base + RANDOM_TICKS) begin
      calm = (ticks_sent >= base + 500) && (ticks_sent < base + 800);
      sel_kind = $urandom_range(0, 99);
      if (sel_kind < 50) begin
        m = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 3) != 0) m = 3'b001 << $urandom_range(0, 2);
        tap_keys(!m[0], !m[1], !m[2], $urandom_range(1, 6), $urandom_range(1, 3));
      end else if (sel_kind < 65) begin
        tap_keys(1, 1, 0, $urandom_range(41, 44), $urandom_range(1, 3));
      end else if (sel_kind < 75) begin
        m = 3'b001 << $urandom_range(0, 1);
        tap_keys(!m[0], !m[1], 1, $urandom_range(41, 46), $urandom_range(1, 2));
      end else if (sel_kind < 90) begin
        for (i = $urandom_range(1, 8); i > 0; i--) begin
          play_tick(ckc_in_word_t'({3'($urandom_range(0, 7)), pick_time()}), 1'b0, '0);
        end
      end else begin
        // Mode held just short of a long press
        tap_keys(1, 1, 0, $urandom_range(30, 40), $urandom_range(1, 2));
      end
    end
    calm = 1'b0;
    tick_in_bus.valid <= 1'b0;

    while (panel_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS three_key_clock_set_controller");
    end else begin
      $display("FAIL three_key_clock_set_controller");
    end
    $finish;
  end

endmodule
